@@ sv/bpj_pkg.sv @@
package bpj_pkg;

   localparam int CENTER_W  = 16;
   localparam int INV_W     = 27;
   localparam int FAR_W     = 16;
   localparam int COLOR_W   = 8;
   localparam int XY_W      = 23;
   localparam int CSR_W     = 27;
   localparam int CSR_IDX_W = 3;

   // The operand a of the wide product a * inv is split at this bit into two partial products.
   localparam int LO_SPLIT = 20;

   localparam logic [CENTER_W-1:0] CENTER_COL_RESET = 16'd5120;
   localparam logic [CENTER_W-1:0] CENTER_ROW_RESET = 16'd3840;
   localparam logic [INV_W-1:0]    INV_FOCAL_RESET  = 27'd7158278;
   localparam logic [FAR_W-1:0]    FAR_LIMIT_RESET  = 16'd65535;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_COL  = 3'd0,
      CSR_CENTER_ROW  = 3'd1,
      CSR_INV_FOCAL_X = 3'd2,
      CSR_INV_FOCAL_Y = 3'd3,
      CSR_FAR_LIMIT   = 3'd4
   } bpj_csr_type;

   // Load enables of the four pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } bpj_stage_en_type;

endpackage

@@ sv/bpj_if.sv @@
interface bpj_req_if #(
   parameter int COORD_BITS = 12,
   parameter int DEPTH_BITS = 16
);
   import bpj_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_col;
   logic [COORD_BITS-1:0] pixel_row;
   logic [DEPTH_BITS-1:0] depth_mm;
   logic [COLOR_W-1:0]    blue_in;
   logic [COLOR_W-1:0]    green_in;
   logic [COLOR_W-1:0]    red_in;

   modport source (
      output valid, pixel_col, pixel_row, depth_mm, blue_in, green_in, red_in,
      input  ready
   );

   modport sink (
      input  valid, pixel_col, pixel_row, depth_mm, blue_in, green_in, red_in,
      output ready
   );
endinterface

interface bpj_rsp_if #(
   parameter int DEPTH_BITS = 16
);
   import bpj_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [XY_W-1:0] point_x_mm;
   logic signed [XY_W-1:0] point_y_mm;
   logic [DEPTH_BITS-1:0]  point_z_mm;
   logic [COLOR_W-1:0]     blue_out;
   logic [COLOR_W-1:0]     green_out;
   logic [COLOR_W-1:0]     red_out;

   modport source (
      output valid, point_x_mm, point_y_mm, point_z_mm, blue_out, green_out, red_out,
      input  ready
   );

   modport sink (
      input  valid, point_x_mm, point_y_mm, point_z_mm, blue_out, green_out, red_out,
      output ready
   );
endinterface

@@ sv/depth_pixel_backproject_top.sv @@
// Pinhole back-projection of depth and color pixels into colored 3D points.
// A kept pixel is registered in each pipeline stage before it appears on the result channel, and a stall holds it.
// Throughput: one pixel per cycle through the four-stage multiply pipeline while the result channel takes words.
// Pixels with zero depth or depth above the far limit are accepted and give no word.
// Reset empties the pipeline and loads the default camera registers.
module depth_pixel_backproject_top #(
   parameter int COORD_BITS    = 12,
   parameter int DEPTH_BITS    = 16,
   parameter int INV_FRAC_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   bpj_req_if.sink                           req_chan,
   bpj_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [bpj_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpj_pkg::CSR_W-1:0]         csr_wdata
);
   import bpj_pkg::*;

   localparam int CMP_W  = (DEPTH_BITS > FAR_W) ? DEPTH_BITS : FAR_W;
   localparam int SIDE_W = DEPTH_BITS + 3 * COLOR_W;

   logic [CENTER_W-1:0] center_col_ff;
   logic [CENTER_W-1:0] center_row_ff;
   logic [INV_W-1:0]    inv_focal_x_ff;
   logic [INV_W-1:0]    inv_focal_y_ff;
   logic [FAR_W-1:0]    far_limit_ff;

   bpj_stage_en_type    stage_en;
   logic                keep;
   logic [3:0]          go_vec;
   logic [SIDE_W-1:0]   side_in;
   logic [SIDE_W-1:0]   side_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff  <= CENTER_COL_RESET;
         center_row_ff  <= CENTER_ROW_RESET;
         inv_focal_x_ff <= INV_FOCAL_RESET;
         inv_focal_y_ff <= INV_FOCAL_RESET;
         far_limit_ff   <= FAR_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_COL:  center_col_ff  <= csr_wdata[CENTER_W-1:0];
            CSR_CENTER_ROW:  center_row_ff  <= csr_wdata[CENTER_W-1:0];
            CSR_INV_FOCAL_X: inv_focal_x_ff <= csr_wdata[INV_W-1:0];
            CSR_INV_FOCAL_Y: inv_focal_y_ff <= csr_wdata[INV_W-1:0];
            CSR_FAR_LIMIT:   far_limit_ff   <= csr_wdata[FAR_W-1:0];
            default: ;
         endcase
      end
   end

   // Depth pass-through filter.
   assign keep = (req_chan.depth_mm != '0) &&
                 (CMP_W'(req_chan.depth_mm) <= CMP_W'(far_limit_ff));

   bpj_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .keep      (keep),
      .in_ready  (req_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .stage_en  (stage_en)
   );

   bpj_axis #(
      .COORD_BITS    (COORD_BITS),
      .DEPTH_BITS    (DEPTH_BITS),
      .INV_FRAC_BITS (INV_FRAC_BITS)
   ) u_axis_x (
      .clock     (clock),
      .stage_en  (stage_en),
      .pix       (req_chan.pixel_col),
      .center    (center_col_ff),
      .depth     (req_chan.depth_mm),
      .inv_focal (inv_focal_x_ff),
      .coord     (rsp_chan.point_x_mm)
   );

   bpj_axis #(
      .COORD_BITS    (COORD_BITS),
      .DEPTH_BITS    (DEPTH_BITS),
      .INV_FRAC_BITS (INV_FRAC_BITS)
   ) u_axis_y (
      .clock     (clock),
      .stage_en  (stage_en),
      .pix       (req_chan.pixel_row),
      .center    (center_row_ff),
      .depth     (req_chan.depth_mm),
      .inv_focal (inv_focal_y_ff),
      .coord     (rsp_chan.point_y_mm)
   );

   // Depth and color ride alongside the coordinate pipeline.
   assign go_vec  = {stage_en.s4, stage_en.s3, stage_en.s2, stage_en.s1};
   assign side_in = {req_chan.depth_mm, req_chan.blue_in, req_chan.green_in,
                     req_chan.red_in};

   always_ff @(posedge clock) begin
      if (go_vec[0]) begin
         side_ff[0] <= side_in;
      end
      for (int k = 1; k < 4; k++) begin
         if (go_vec[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign rsp_chan.point_z_mm = side_ff[3][SIDE_W-1:3*COLOR_W];
   assign rsp_chan.blue_out   = side_ff[3][3*COLOR_W-1:2*COLOR_W];
   assign rsp_chan.green_out  = side_ff[3][2*COLOR_W-1:COLOR_W];
   assign rsp_chan.red_out    = side_ff[3][COLOR_W-1:0];

endmodule

@@ sv/bpj_flow.sv @@
module bpj_flow (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic                       keep,
   output logic                       in_ready,
   output logic                       out_valid,
   input  logic                       out_ready,
   output bpj_pkg::bpj_stage_en_type  stage_en
);
   import bpj_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic go1, go2, go3, go4;

   // A stage may load when it is empty or its word moves on in the same cycle.
   assign go4 = !v4_ff || out_ready;
   assign go3 = !v3_ff || go4;
   assign go2 = !v2_ff || go3;
   assign go1 = !v1_ff || go2;

   // Filtered pixels are accepted but never enter the pipeline.
   assign v1_in = go1 ? (in_valid && keep) : v1_ff;
   assign v2_in = go2 ? v1_ff : v2_ff;
   assign v3_in = go3 ? v2_ff : v3_ff;
   assign v4_in = go4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign in_ready    = go1;
   assign out_valid   = v4_ff;
   assign stage_en.s1 = go1;
   assign stage_en.s2 = go2;
   assign stage_en.s3 = go3;
   assign stage_en.s4 = go4;

`ifndef SYNTHESIS
   a_drop_filtered: assert property (@(posedge clock) disable iff (reset)
      (in_valid && go1 && !keep) |=> !v1_ff)
      else $error("filtered pixel entered the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && v4_ff && !out_ready) |=> (v3_ff && v4_ff))
      else $error("stalled word lost inside the pipeline");

   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !go1 |-> (v1_ff && v2_ff && v3_ff && v4_ff && !out_ready))
      else $error("input held off while the pipeline has room");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && go3) |=> v3_ff)
      else $error("word lost between stages two and three");
`endif

endmodule

@@ sv/bpj_axis.sv @@
module bpj_axis #(
   parameter int COORD_BITS    = 12,
   parameter int DEPTH_BITS    = 16,
   parameter int INV_FRAC_BITS = 32
) (
   input  logic                             clock,
   input  bpj_pkg::bpj_stage_en_type        stage_en,
   input  logic [COORD_BITS-1:0]            pix,
   input  logic [bpj_pkg::CENTER_W-1:0]     center,
   input  logic [DEPTH_BITS-1:0]            depth,
   input  logic [bpj_pkg::INV_W-1:0]        inv_focal,
   output logic signed [bpj_pkg::XY_W-1:0]  coord
);
   import bpj_pkg::*;

   localparam int P16_W   = COORD_BITS + 4;
   localparam int DIFF_W  = (P16_W > CENTER_W) ? P16_W : CENTER_W;
   localparam int A_W     = DIFF_W + DEPTH_BITS;
   localparam int HI_W    = A_W - LO_SPLIT;
   localparam int PLO_W   = LO_SPLIT + INV_W;
   localparam int PHI_W   = HI_W + INV_W;
   localparam int T_W     = PHI_W + 1;
   localparam int SHIFT   = INV_FRAC_BITS - 16;
   localparam int RND_POS = INV_FRAC_BITS - 17;

   localparam logic [T_W-1:0] RND     = T_W'(1) << RND_POS;
   localparam logic [T_W-1:0] POS_MAX = (T_W'(1) << (XY_W - 1)) - T_W'(1);
   localparam logic [T_W-1:0] NEG_MAX = T_W'(1) << (XY_W - 1);

   logic [DIFF_W-1:0]     p16;
   logic [DIFF_W-1:0]     cen_ext;
   logic                  neg_in;
   logic [DIFF_W-1:0]     diff_in;
   logic [DIFF_W-1:0]     diff_ff;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic                  neg1_ff;

   logic [A_W-1:0]        a_in;
   logic [A_W-1:0]        a_ff;
   logic                  neg2_ff;

   logic [PLO_W-1:0]      plo_in;
   logic [PHI_W-1:0]      phi_in;
   logic [PLO_W-1:0]      plo_ff;
   logic [PHI_W-1:0]      phi_ff;
   logic                  neg3_ff;

   logic [T_W-1:0]        t_sum;
   logic [T_W-1:0]        mag;
   logic [T_W-1:0]        mag_sat;
   logic [XY_W-1:0]       coord_in;
   logic [XY_W-1:0]       coord_ff;

   // Stage 1: signed offset from the principal point, kept as sign and magnitude.
   assign p16     = DIFF_W'({pix, 4'b0000});
   assign cen_ext = DIFF_W'(center);
   assign neg_in  = p16 < cen_ext;
   assign diff_in = neg_in ? (cen_ext - p16) : (p16 - cen_ext);

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         diff_ff  <= diff_in;
         depth_ff <= depth;
         neg1_ff  <= neg_in;
      end
   end

   // Stage 2: offset times depth.
   assign a_in = A_W'(diff_ff) * A_W'(depth_ff);

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         a_ff    <= a_in;
         neg2_ff <= neg1_ff;
      end
   end

   // Stage 3: the product with the inverse focal length in two partial products.
   assign plo_in = PLO_W'(a_ff[LO_SPLIT-1:0]) * PLO_W'(inv_focal);
   assign phi_in = PHI_W'(a_ff[A_W-1:LO_SPLIT]) * PHI_W'(inv_focal);

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         neg3_ff <= neg2_ff;
      end
   end

   // Stage 4: recombine, round half away from zero, saturate and apply the sign.
   assign t_sum = T_W'(phi_ff) + T_W'(plo_ff[PLO_W-1:LO_SPLIT]) + RND;
   assign mag   = t_sum >> SHIFT;

   always_comb begin
      if (neg3_ff) begin
         mag_sat  = (mag > NEG_MAX) ? NEG_MAX : mag;
         coord_in = XY_W'(0) - mag_sat[XY_W-1:0];
      end else begin
         mag_sat  = (mag > POS_MAX) ? POS_MAX : mag;
         coord_in = mag_sat[XY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         coord_ff <= coord_in;
      end
   end

   assign coord = signed'(coord_ff);

endmodule

@@ test/point_checker.sv @@
`timescale 1ns / 100ps

module point_checker #(
   parameter int COORD_BITS    = 12,
   parameter int DEPTH_BITS    = 16,
   parameter int INV_FRAC_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   bpj_req_if                            pixel_mon,
   bpj_rsp_if                            point_mon,
   input  logic                          csr_we,
   input  logic [bpj_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bpj_pkg::CSR_W-1:0]     csr_wdata,
   output int                            mismatches,
   output int                            points_pending,
   output int                            points_seen
);
   import bpj_pkg::*;

   localparam int          ROUND_SHIFT = INV_FRAC_BITS + 4;
   localparam logic [63:0] XY_POS_MAX  = (64'd1 << (XY_W - 1)) - 1;
   localparam logic [63:0] XY_NEG_MAG  = 64'd1 << (XY_W - 1);

   typedef struct packed {
      logic signed [XY_W-1:0] x_mm;
      logic signed [XY_W-1:0] y_mm;
      logic [DEPTH_BITS-1:0]  z_mm;
      logic [COLOR_W-1:0]     blue;
      logic [COLOR_W-1:0]     green;
      logic [COLOR_W-1:0]     red;
   } point_type;

   // Camera registers as the block should hold them.
   logic [CENTER_W-1:0] cam_center_col;
   logic [CENTER_W-1:0] cam_center_row;
   logic [INV_W-1:0]    cam_inv_x;
   logic [INV_W-1:0]    cam_inv_y;
   logic [FAR_W-1:0]    cam_far;

   point_type point_q[$];

   // One axis of the pinhole model, with the product kept exact in 64 bits.
   function automatic logic [XY_W-1:0] project_coord(input logic [COORD_BITS-1:0] pix,
                                                     input logic [CENTER_W-1:0]   center,
                                                     input logic [DEPTH_BITS-1:0] depth,
                                                     input logic [INV_W-1:0]      inv);
      logic [CENTER_W-1:0] pix_q4;
      logic                is_neg;
      logic [CENTER_W-1:0] span;
      logic [63:0]         mag;
      pix_q4 = CENTER_W'({pix, 4'b0000});
      is_neg = pix_q4 < center;
      span = is_neg ? center - pix_q4 : pix_q4 - center;
      mag = (64'(span) * 64'(depth) * 64'(inv) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      if (is_neg) begin
         if (mag > XY_NEG_MAG) mag = XY_NEG_MAG;
         return XY_W'(64'd0 - mag);
      end
      if (mag > XY_POS_MAX) mag = XY_POS_MAX;
      return mag[XY_W-1:0];
   endfunction

   function automatic int field_diff(input string name, input longint want, input longint got);
      if (want == got) return 0;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
   endfunction

   always @(posedge clock) begin
      point_type seen;
      point_type want;
      int        bad;
      bad = 0;
      if (reset) begin
         cam_center_col <= CENTER_COL_RESET;
         cam_center_row <= CENTER_ROW_RESET;
         cam_inv_x <= INV_FOCAL_RESET;
         cam_inv_y <= INV_FOCAL_RESET;
         cam_far <= FAR_LIMIT_RESET;
         point_q.delete();
         points_pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CENTER_COL: cam_center_col <= csr_wdata[CENTER_W-1:0];
               CSR_CENTER_ROW: cam_center_row <= csr_wdata[CENTER_W-1:0];
               CSR_INV_FOCAL_X: cam_inv_x <= csr_wdata[INV_W-1:0];
               CSR_INV_FOCAL_Y: cam_inv_y <= csr_wdata[INV_W-1:0];
               CSR_FAR_LIMIT: cam_far <= csr_wdata[FAR_W-1:0];
               default: ;
            endcase
         end

         if (point_mon.valid && point_mon.ready) begin
            seen.x_mm = point_mon.point_x_mm;
            seen.y_mm = point_mon.point_y_mm;
            seen.z_mm = point_mon.point_z_mm;
            seen.blue = point_mon.blue_out;
            seen.green = point_mon.green_out;
            seen.red = point_mon.red_out;
            points_seen <= points_seen + 1;
            if (point_q.size() == 0) begin
               $display("%0t: unexpected point word x %0d y %0d z %0d, expected none",
                        $time, seen.x_mm, seen.y_mm, seen.z_mm);
               bad = 1;
            end else begin
               want = point_q.pop_front();
               bad += field_diff("point_x_mm", want.x_mm, seen.x_mm);
               bad += field_diff("point_y_mm", want.y_mm, seen.y_mm);
               bad += field_diff("point_z_mm", want.z_mm, seen.z_mm);
               bad += field_diff("blue_out", want.blue, seen.blue);
               bad += field_diff("green_out", want.green, seen.green);
               bad += field_diff("red_out", want.red, seen.red);
            end
         end

         // A pixel with no reading or beyond the far limit leaves no word behind.
         if (pixel_mon.valid && pixel_mon.ready && pixel_mon.depth_mm != 0 &&
             pixel_mon.depth_mm <= cam_far) begin
            want.x_mm = project_coord(pixel_mon.pixel_col, cam_center_col,
                                      pixel_mon.depth_mm, cam_inv_x);
            want.y_mm = project_coord(pixel_mon.pixel_row, cam_center_row,
                                      pixel_mon.depth_mm, cam_inv_y);
            want.z_mm = pixel_mon.depth_mm;
            want.blue = pixel_mon.blue_in;
            want.green = pixel_mon.green_in;
            want.red = pixel_mon.red_in;
            point_q.insert(point_q.size(), want);
         end
         points_pending <= point_q.size();
         if (bad != 0) mismatches <= mismatches + bad;
      end
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import bpj_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 100000;
   localparam int PHASES        = 7;
   localparam int PHASE_PIXELS  = 150;
   localparam int IDLE_PCT      = 19;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   typedef struct {
      logic [11:0]        col;
      logic [11:0]        row;
      logic [15:0]        depth;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic [FAR_W-1:0]     far_now;
   int                   send_idle_pct;
   int                   recv_idle_pct;
   int                   cycles = 0;
   int                   pixels_sent = 0;
   int                   settings_used = 0;
   int                   mismatches;
   int                   points_pending;
   int                   points_seen;

   bpj_req_if req_chan ();
   bpj_rsp_if rsp_chan ();

   depth_pixel_backproject_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   point_checker point_check (
      .clock         (clock),
      .reset         (reset),
      .pixel_mon     (req_chan),
      .point_mon     (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .points_pending(points_pending),
      .points_seen   (points_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready = !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_FAR_LIMIT) far_now = value[FAR_W-1:0];
   endtask

   task automatic set_camera(input logic [CSR_W-1:0] center_col, input logic [CSR_W-1:0] center_row,
                             input logic [CSR_W-1:0] inv_x, input logic [CSR_W-1:0] inv_y,
                             input logic [CSR_W-1:0] far_mm);
      write_reg(CSR_CENTER_COL, center_col);
      write_reg(CSR_CENTER_ROW, center_row);
      write_reg(CSR_INV_FOCAL_X, inv_x);
      write_reg(CSR_INV_FOCAL_Y, inv_y);
      write_reg(CSR_FAR_LIMIT, far_mm);
      settings_used++;
   endtask

   // Dropped pixels give no word, so after the checker's queue drains the pipeline is left to empty.
   task automatic settle();
      req_chan.valid = 1'b0;
      while (points_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_pixel(input pixel_type px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.pixel_col = px.col;
      req_chan.pixel_row = px.row;
      req_chan.depth_mm = px.depth;
      req_chan.blue_in = px.blue;
      req_chan.green_in = px.green;
      req_chan.red_in = px.red;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pixels_sent++;
      @(negedge clock);
   endtask

   function automatic pixel_type make_pixel(input int col, input int row, input int depth,
                                            input int blue, input int green, input int red);
      pixel_type px;
      px.col = 12'(col);
      px.row = 12'(row);
      px.depth = 16'(depth);
      px.blue = COLOR_W'(blue);
      px.green = COLOR_W'(green);
      px.red = COLOR_W'(red);
      return px;
   endfunction

   function automatic logic [11:0] random_coord();
      case ($urandom_range(0, 9))
         0: return 12'd0;
         1: return 12'hFFF;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type   px;
      int unsigned pick;
      px.col = random_coord();
      px.row = random_coord();
      pick = $urandom_range(0, 99);
      if (pick < 6) px.depth = '0;
      else if (pick < 14 && far_now != 16'hFFFF)
         px.depth = 16'($urandom_range(far_now + 1, 65535));
      else if (pick < 22) px.depth = 16'($urandom_range(1, 16));
      else px.depth = 16'($urandom_range(1, far_now));
      px.blue = COLOR_W'($urandom);
      px.green = COLOR_W'($urandom);
      px.red = COLOR_W'($urandom);
      return px;
   endfunction

   function automatic logic [CSR_W-1:0] random_center();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return CSR_W'(16'hFFFF);
         default: return CSR_W'(16'($urandom));
      endcase
   endfunction

   // Realistic and random focal lengths, with the extremes that force saturation or zero.
   function automatic logic [CSR_W-1:0] random_inv_focal();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 27'h7FFFFFF;
         2: return 27'h4000000;
         3, 4: return CSR_W'($urandom_range(27'h0400000, 27'h1000000));
         default: return 27'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] random_far();
      case ($urandom_range(0, 2))
         0: return CSR_W'(16'hFFFF);
         1: return CSR_W'($urandom_range(500, 8000));
         default: return CSR_W'($urandom_range(1, 65535));
      endcase
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pixel_col = '0;
      req_chan.pixel_row = '0;
      req_chan.depth_mm = '0;
      req_chan.blue_in = '0;
      req_chan.green_in = '0;
      req_chan.red_in = '0;
      rsp_chan.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_CENTER_COL;
      csr_wdata = '0;
      far_now = FAR_LIMIT_RESET;
      send_idle_pct = IDLE_PCT;
      recv_idle_pct = IDLE_PCT;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Camera as it comes out of reset: center, corners and a pixel with no reading.
      send_pixel(make_pixel(320, 240, 1000, 0, 0, 0));
      send_pixel(make_pixel(0, 0, 65535, 255, 255, 255));
      send_pixel(make_pixel(4095, 4095, 65535, 8'h55, 8'hAA, 8'h0F));
      send_pixel(make_pixel(4095, 0, 1, 0, 255, 0));
      send_pixel(make_pixel(100, 200, 0, 1, 2, 3));
      settle();

      // One pixel off center at this depth lands exactly on half a millimetre,
      // which must round away from zero on both sides; the far limit is inclusive.
      set_camera(CENTER_COL_RESET, CENTER_ROW_RESET, 27'h4000000, 27'h4000000, 1000);
      send_pixel(make_pixel(321, 241, 32, 9, 8, 7));
      send_pixel(make_pixel(319, 239, 32, 7, 8, 9));
      send_pixel(make_pixel(10, 4000, 1000, 1, 1, 1));
      send_pixel(make_pixel(10, 4000, 1001, 2, 2, 2));
      settle();

      // Largest inverse focal length drives both axes into saturation.
      set_camera(0, 16'hFFFF, 27'h7FFFFFF, 27'h7FFFFFF, 16'hFFFF);
      send_pixel(make_pixel(4095, 0, 65535, 3, 4, 5));
      send_pixel(make_pixel(0, 4095, 65535, 6, 7, 8));
      send_pixel(make_pixel(4095, 4095, 40000, 128, 127, 64));
      settle();

      // Zero inverse focal length, and bits above the 16-bit registers are dropped.
      set_camera(27'h7FF0000 | 27'd6000, 27'h5A50000 | 27'd3000, 0, 0, 27'h7FF0000 | 27'hFFFF);
      send_pixel(make_pixel(0, 0, 65535, 11, 22, 33));
      send_pixel(make_pixel(4095, 4095, 1, 44, 55, 66));
      settle();

      // Writes to unassigned indexes change nothing; a far limit of zero drops all.
      for (int idx = CSR_UNUSED_LO; idx <= CSR_UNUSED_HI; idx++)
         write_reg(CSR_IDX_W'(idx), CSR_W'($urandom));
      write_reg(CSR_FAR_LIMIT, 0);
      send_pixel(make_pixel(320, 240, 1, 0, 0, 0));
      send_pixel(make_pixel(4095, 4095, 65535, 255, 255, 255));
      settle();
      write_reg(CSR_FAR_LIMIT, 16'hFFFF);
      send_pixel(make_pixel(2048, 2048, 30000, 90, 91, 92));

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         set_camera(random_center(), random_center(), random_inv_focal(), random_inv_focal(),
                    random_far());
         send_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
         recv_idle_pct = (phase == 2) ? 0 : IDLE_PCT;
         for (int i = 0; i < PHASE_PIXELS; i++) begin
            if (phase == 4 && i == PHASE_PIXELS / 2) settle();
            send_pixel(random_pixel());
         end
      end
      settle();

      $display("Sent %0d pixels under %0d camera settings, including saturation,",
               pixels_sent, settings_used);
      $display("rounding halves and far-limit drops; %0d point words compared.", points_seen);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/bpj_pkg.sv
sv/bpj_if.sv
sv/bpj_flow.sv
sv/bpj_axis.sv
sv/depth_pixel_backproject_top.sv
test/point_checker.sv
test/testbench.sv
